>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TWG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/twg_pkg.sv
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types, constants and the seven-segment decoder of the wave generator.
// ----------------------------------------------------------------------------
`default_nettype none

package twg_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int PHASE_BITS  = 17;
	localparam int AMP_BITS    = 15;
	localparam int SPS_BITS    = 18;
	localparam int SEG_BITS    = 7;
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [AMP_BITS-1:0] AMPLITUDE_RST  = 15'd30000;
	localparam logic [AMP_BITS-1:0] PHASE_STEP_RST = 15'd300;
	localparam logic [SPS_BITS-1:0] SPS_RST        = 18'd48000;
	localparam logic signed [PHASE_BITS-1:0] PHASE_RST = -17'sd30000;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_AMPLITUDE  = 2'd0,
		REG_PHASE_STEP = 2'd1,
		REG_SPS        = 2'd2
	} twg_reg_t;

	typedef enum logic [1:0] {
		WAVE_SAW    = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_TRI    = 2'd2
	} twg_wave_t;

	typedef struct packed {
		logic take;   // an item leaves the input stage
		logic emit;   // that item produces a sample
	} twg_ctl_t;

	typedef struct packed {
		logic [SEG_BITS-1:0] mins_hi;
		logic [SEG_BITS-1:0] mins_lo;
		logic [SEG_BITS-1:0] secs_hi;
		logic [SEG_BITS-1:0] secs_lo;
	} twg_seg_t;

	// segments A-G in bits 0-6
	function automatic logic [SEG_BITS-1:0] seg_code(input logic [3:0] digit);
		logic [SEG_BITS-1:0] code;
		case (digit)
			4'd0: code = 7'b0111111;
			4'd1: code = 7'b0000110;
			4'd2: code = 7'b1011011;
			4'd3: code = 7'b1001111;
			4'd4: code = 7'b1100110;
			4'd5: code = 7'b1101101;
			4'd6: code = 7'b1111101;
			4'd7: code = 7'b0000111;
			4'd8: code = 7'b1111111;
			4'd9: code = 7'b1101111;
			default: code = 7'b0000000;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> rtl/twg_if.sv
// ----------------------------------------------------------------------------
// twg_if
// Valid/ready channels for button polls and generated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface twg_poll_if;
	logic valid;
	logic ready;
	logic next_level;
	logic prev_level;
	logic pause_level;

	modport source (output valid, output next_level, output prev_level,
		output pause_level, input ready);
	modport sink (input valid, input next_level, input prev_level,
		input pause_level, output ready);
endinterface

interface twg_result_if;
	logic        valid;
	logic        ready;
	logic signed [twg_pkg::SAMPLE_BITS-1:0] sample;
	logic        sample_valid;
	logic [1:0]  wave_now;
	logic [twg_pkg::SEG_BITS-1:0] seg_min_tens;
	logic [twg_pkg::SEG_BITS-1:0] seg_min_units;
	logic [twg_pkg::SEG_BITS-1:0] seg_sec_tens;
	logic [twg_pkg::SEG_BITS-1:0] seg_sec_units;

	modport source (output valid, output sample, output sample_valid,
		output wave_now, output seg_min_tens, output seg_min_units,
		output seg_sec_tens, output seg_sec_units, input ready);
	modport sink (input valid, input sample, input sample_valid,
		input wave_now, input seg_min_tens, input seg_min_units,
		input seg_sec_tens, input seg_sec_units, output ready);
endinterface

`default_nettype wire

>>> rtl/twg_wave.sv
// ----------------------------------------------------------------------------
// twg_wave
// Wave selection from button edges and the phase accumulator with its shapes.
// ----------------------------------------------------------------------------
`default_nettype none

module twg_wave (
	input  logic clk,
	input  logic arst_n,
	input  twg_pkg::twg_ctl_t ctl,
	input  logic next_level,
	input  logic prev_level,
	input  logic [twg_pkg::AMP_BITS-1:0] amplitude,
	input  logic [twg_pkg::AMP_BITS-1:0] phase_step,
	output twg_pkg::twg_wave_t wave_now,
	output logic signed [twg_pkg::SAMPLE_BITS-1:0] sample
);

	twg_pkg::twg_wave_t wave_q, wave_inc, wave_dec;
	logic last_next_q, last_prev_q, rising_q;
	logic signed [twg_pkg::PHASE_BITS-1:0] phase_q, phase_nx;
	logic signed [twg_pkg::PHASE_BITS-1:0] amp_ext, neg_amp, phase_up, phase_dn;
	logic rising_nx;
	logic rise_next, rise_prev;

	always_comb begin
		case (wave_q)
			twg_pkg::WAVE_SAW:    wave_inc = twg_pkg::WAVE_SQUARE;
			twg_pkg::WAVE_SQUARE: wave_inc = twg_pkg::WAVE_TRI;
			default:              wave_inc = twg_pkg::WAVE_SAW;
		endcase
		case (wave_q)
			twg_pkg::WAVE_SAW:    wave_dec = twg_pkg::WAVE_TRI;
			twg_pkg::WAVE_SQUARE: wave_dec = twg_pkg::WAVE_SAW;
			default:              wave_dec = twg_pkg::WAVE_SQUARE;
		endcase
	end

	assign rise_next = next_level & ~last_next_q;
	assign rise_prev = prev_level & ~last_prev_q;

	// both edges in one poll cancel
	always_comb begin
		case ({rise_next, rise_prev})
			2'b10:   wave_now = wave_inc;
			2'b01:   wave_now = wave_dec;
			default: wave_now = wave_q;
		endcase
	end

	assign amp_ext  = {2'b00, amplitude};
	assign neg_amp  = twg_pkg::PHASE_BITS'(17'd0 - amp_ext);
	assign phase_up = phase_q + {2'b00, phase_step};
	assign phase_dn = phase_q - {2'b00, phase_step};

	always_comb begin
		phase_nx  = phase_up;
		rising_nx = rising_q;
		if (wave_now == twg_pkg::WAVE_TRI) begin
			if (rising_q) begin
				phase_nx = phase_up;
				if (phase_up >= amp_ext) rising_nx = 1'b0;
			end else begin
				phase_nx = phase_dn;
				if (phase_dn <= neg_amp) rising_nx = 1'b1;
			end
		end else if (phase_up > amp_ext) begin
			phase_nx = neg_amp;
		end
	end

	always_comb begin
		if (!ctl.emit) begin
			sample = '0;
		end else if (wave_now == twg_pkg::WAVE_SQUARE) begin
			sample = phase_q[twg_pkg::PHASE_BITS-1] ? neg_amp[twg_pkg::SAMPLE_BITS-1:0]
				: amp_ext[twg_pkg::SAMPLE_BITS-1:0];
		end else begin
			sample = phase_q[twg_pkg::SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q      <= twg_pkg::WAVE_SAW;
			last_next_q <= 1'b0;
			last_prev_q <= 1'b0;
			phase_q     <= twg_pkg::PHASE_RST;
			rising_q    <= 1'b1;
		end else begin
			if (ctl.take) begin
				wave_q      <= wave_now;
				last_next_q <= next_level;
				last_prev_q <= prev_level;
			end
			if (ctl.emit) begin
				phase_q  <= phase_nx;
				rising_q <= rising_nx;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/twg_timer.sv
// ----------------------------------------------------------------------------
// twg_timer
// Elapsed-time counter in decimal digits with seven-segment decode.
// ----------------------------------------------------------------------------
`default_nettype none

module twg_timer (
	input  logic clk,
	input  logic arst_n,
	input  twg_pkg::twg_ctl_t ctl,
	input  logic [twg_pkg::SPS_BITS-1:0] samples_per_second,
	output twg_pkg::twg_seg_t seg
);

	logic [twg_pkg::SPS_BITS-1:0] sub_q, sub_nx, limit;
	logic [twg_pkg::SPS_BITS:0]   sub_inc;
	logic [3:0] sec_u_q, min_u_q, min_t_q, sec_u_nx, min_u_nx, min_t_nx;
	logic [2:0] sec_t_q, sec_t_nx;
	logic second_done;

	assign limit       = (samples_per_second == '0) ? twg_pkg::SPS_BITS'(1)
		: samples_per_second;
	assign sub_inc     = {1'b0, sub_q} + 19'd1;
	assign second_done = ctl.emit && (sub_inc >= {1'b0, limit});

	// carry through the digits; wrap after 99:59
	always_comb begin
		sub_nx   = ctl.emit ? sub_inc[twg_pkg::SPS_BITS-1:0] : sub_q;
		sec_u_nx = sec_u_q;
		sec_t_nx = sec_t_q;
		min_u_nx = min_u_q;
		min_t_nx = min_t_q;
		if (second_done) begin
			sub_nx = '0;
			if (sec_u_q != 4'd9) begin
				sec_u_nx = sec_u_q + 4'd1;
			end else begin
				sec_u_nx = 4'd0;
				if (sec_t_q != 3'd5) begin
					sec_t_nx = sec_t_q + 3'd1;
				end else begin
					sec_t_nx = 3'd0;
					if (min_u_q != 4'd9) begin
						min_u_nx = min_u_q + 4'd1;
					end else begin
						min_u_nx = 4'd0;
						min_t_nx = (min_t_q == 4'd9) ? 4'd0 : min_t_q + 4'd1;
					end
				end
			end
		end
	end

	assign seg.mins_hi = twg_pkg::seg_code(min_t_nx);
	assign seg.mins_lo = twg_pkg::seg_code(min_u_nx);
	assign seg.secs_hi = twg_pkg::seg_code({1'b0, sec_t_nx});
	assign seg.secs_lo = twg_pkg::seg_code(sec_u_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q   <= '0;
			sec_u_q <= '0;
			sec_t_q <= '0;
			min_u_q <= '0;
			min_t_q <= '0;
		end else if (ctl.emit) begin
			sub_q   <= sub_nx;
			sec_u_q <= sec_u_nx;
			sec_t_q <= sec_t_nx;
			min_u_q <= min_u_nx;
			min_t_q <= min_t_nx;
		end
	end

endmodule

`default_nettype wire

>>> rtl/three_wave_generator_with_timer.sv
// ----------------------------------------------------------------------------
// three_wave_generator_with_timer
// Sawtooth / square / triangle generator with an mm:ss elapsed-sample clock.
// ----------------------------------------------------------------------------
// Each poll transaction on the poll channel gives exactly one result
// transaction: the wave choice after the button edges of that poll, one
// 16-bit sample (zero with sample_valid low when pause_level is set), and
// the elapsed time as four seven-segment codes. A poll is registered in an
// input stage, then combinational logic (wave step, phase update, time
// carry) loads the result register; one poll is taken every clock while the
// result side keeps up, and the throughput limit is the state update of the
// phase accumulator and time counter. Polls keep flowing while a finished
// result waits, until both the input stage and the result register are full.
// Registers (APB, 32-bit data): 0x0 amplitude, 0x4 phase_step,
// 0x8 samples_per_second (0 counts as 1).
// Write them only while no poll is in flight.
`default_nettype none

module three_wave_generator_with_timer (
	input  logic clk,
	input  logic arst_n,
	twg_poll_if.sink     poll,
	twg_result_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [twg_pkg::ADDR_BITS-1:0] paddr,
	input  logic [twg_pkg::DATA_BITS-1:0] pwdata,
	output logic [twg_pkg::DATA_BITS-1:0] prdata,
	output logic pready
);

	// configuration registers
	logic [twg_pkg::AMP_BITS-1:0] amplitude_q, phase_step_q;
	logic [twg_pkg::SPS_BITS-1:0] sps_q;
	twg_pkg::twg_reg_t reg_sel;
	logic cfg_write;

	// input stage
	logic valid_s1, next_s1, prev_s1, pause_s1;
	logic adv_s1;

	// result register
	logic out_valid_q, sample_valid_q;
	logic signed [twg_pkg::SAMPLE_BITS-1:0] sample_q, sample_nx;
	twg_pkg::twg_wave_t wave_q, wave_nx;
	twg_pkg::twg_seg_t seg_q, seg_nx;
	twg_pkg::twg_ctl_t ctl;

	assign pready    = 1'b1;
	assign reg_sel   = twg_pkg::twg_reg_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q  <= twg_pkg::AMPLITUDE_RST;
			phase_step_q <= twg_pkg::PHASE_STEP_RST;
			sps_q        <= twg_pkg::SPS_RST;
		end else if (cfg_write) begin
			case (reg_sel)
				twg_pkg::REG_AMPLITUDE:  amplitude_q  <= pwdata[twg_pkg::AMP_BITS-1:0];
				twg_pkg::REG_PHASE_STEP: phase_step_q <= pwdata[twg_pkg::AMP_BITS-1:0];
				twg_pkg::REG_SPS:        sps_q        <= pwdata[twg_pkg::SPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			twg_pkg::REG_AMPLITUDE:  prdata = {17'd0, amplitude_q};
			twg_pkg::REG_PHASE_STEP: prdata = {17'd0, phase_step_q};
			twg_pkg::REG_SPS:        prdata = {14'd0, sps_q};
			default:                 prdata = '0;
		endcase
	end

	// advance the input stage whenever the result register is free or draining
	assign adv_s1     = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || adv_s1;

	assign ctl.take = adv_s1;
	assign ctl.emit = adv_s1 && !pause_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	// payload of the input stage; hold while stalled
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			next_s1  <= poll.next_level;
			prev_s1  <= poll.prev_level;
			pause_s1 <= poll.pause_level;
		end
	end

	twg_wave u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.next_level (next_s1),
		.prev_level (prev_s1),
		.amplitude  (amplitude_q),
		.phase_step (phase_step_q),
		.wave_now   (wave_nx),
		.sample     (sample_nx)
	);

	twg_timer u_timer (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.samples_per_second (sps_q),
		.seg                (seg_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// load the result with the item leaving the input stage
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sample_q       <= sample_nx;
			sample_valid_q <= !pause_s1;
			wave_q         <= wave_nx;
			seg_q          <= seg_nx;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.sample        = sample_q;
	assign result.sample_valid  = sample_valid_q;
	assign result.wave_now      = wave_q;
	assign result.seg_min_tens  = seg_q.mins_hi;
	assign result.seg_min_units = seg_q.mins_lo;
	assign result.seg_sec_tens  = seg_q.secs_hi;
	assign result.seg_sec_units = seg_q.secs_lo;

endmodule

`default_nettype wire

>>> rtl/twg_checker.sv
// ----------------------------------------------------------------------------
// twg_checker
// Port-level checks of the wave generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twg_checker (
	input logic clk,
	input logic arst_n,
	input logic poll_ready,
	input logic result_valid,
	input logic result_ready,
	input logic result_sample_valid,
	input logic signed [twg_pkg::SAMPLE_BITS-1:0] result_sample,
	input logic [1:0] result_wave_now
);

	// a paused step carries a zero sample
	`TWG_ASSERT_IMPL(a_pause_zero, clk, arst_n, result_valid && !result_sample_valid, result_sample == '0, "paused result with nonzero sample")

	// a draining result side never stalls the poll side
	`TWG_ASSERT_IMPL(a_flow_through, clk, arst_n, result_ready, poll_ready, "poll stalled while result side ready")

	// a stalled result holds
	`TWG_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_sample) && $stable(result_wave_now), "stalled result changed")

endmodule

bind three_wave_generator_with_timer twg_checker u_twg_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.poll_ready          (poll.ready),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_sample_valid (result.sample_valid),
	.result_sample       (result.sample),
	.result_wave_now     (result.wave_now)
);

`default_nettype wire
